// ===== hdl/entry_batch_signature_parser_defines.svh =====
// Assertion macros for the entry batch signature parser
`ifndef ENTRY_BATCH_SIGNATURE_PARSER_DEFINES_SVH
`define ENTRY_BATCH_SIGNATURE_PARSER_DEFINES_SVH
`ifndef ASSERT_OFF
`define EBSP_ASSERT_IMPL(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define EBSP_ASSERT_NORST(label, clk, prop) \
    label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define EBSP_ASSERT_IMPL(label, clk, rst_n, prop)
`define EBSP_ASSERT_NORST(label, clk, prop)
`endif
`endif

// ===== hdl/ebsp_pkg.sv =====
// ---------------------------------------------------------------------------
// ebsp_pkg
// Types and constants shared by the entry batch signature parser.
// ---------------------------------------------------------------------------
package ebsp_pkg;

    localparam int SigCapDef         = 4096;
    localparam int MaxEntriesDef     = 4096;
    localparam int MaxTxPerEntryDef  = 4096;
    localparam int MaxKeysDef        = 256;
    localparam int MaxInstrDef       = 256;
    localparam int MaxLutDef         = 32;

    localparam logic [5:0]  EntrySkip   = 6'd40;
    localparam logic [6:0]  MaxSigs     = 7'd64;
    localparam logic [1:0]  StatFull    = 2'd0;
    localparam logic [1:0]  StatPartial = 2'd1;
    localparam logic [1:0]  StatReject  = 2'd2;

    typedef enum logic [4:0] {
        PH_NENT, PH_ESKIP, PH_NTX, PH_NSIG, PH_SIG, PH_SIGSKIP, PH_HDR0, PH_HDRV,
        PH_ROSKIP, PH_NKEYS, PH_KEYSKIP, PH_NINSTR, PH_IXPROG, PH_IXNACC, PH_IXACC,
        PH_IXDLEN, PH_IXDATA, PH_NLUT, PH_LUTKEY, PH_LUTNW, PH_LUTW, PH_LUTNR, PH_LUTR
    } phase_t;

    typedef enum logic [1:0] {
        RUN_ACTIVE = 2'd0,
        RUN_DONE   = 2'd1,
        RUN_FAIL   = 2'd2
    } run_t;

    // One result item, handed from the parser core to the output stage
    typedef struct packed {
        logic        sig_valid;
        logic [7:0]  sig_byte;
        logic [11:0] sig_number;
        logic [5:0]  sig_byte_index;
        logic        tx_done;
        logic        batch_end;
        logic [1:0]  batch_status;
        logic [12:0] sig_count;
    } result_t;

    // Compact-u16 decoder status
    typedef struct packed {
        logic        bad;
        logic        ready;
        logic [15:0] value;
        logic [15:0] value_next;
        logic [1:0]  step_next;
    } varint_t;

endpackage

// ===== hdl/ebsp_varint.sv =====
// ---------------------------------------------------------------------------
// ebsp_varint
// One-byte step of the compact-u16 decoder.
// ---------------------------------------------------------------------------
module ebsp_varint
(
    input  logic [7:0]           data_byte,
    input  logic [15:0]          value_reg,
    input  logic [1:0]           step_reg,
    output ebsp_pkg::varint_t    vi
);

    // decode this byte against the accumulated value
    always_comb
    begin
        vi.bad        = 1'b0;
        vi.ready      = 1'b0;
        vi.value      = value_reg;
        vi.value_next = value_reg;
        vi.step_next  = 2'd0;
        case (step_reg)
            2'd0:
            begin
                if (!data_byte[7])
                begin
                    vi.ready = 1'b1;
                    vi.value = {8'd0, data_byte};
                end
                else
                begin
                    vi.value_next = {9'd0, data_byte[6:0]};
                    vi.step_next  = 2'd1;
                end
                if (!data_byte[7])
                    vi.value_next = {8'd0, data_byte};
            end
            2'd1:
            begin
                if (data_byte[7])
                begin
                    vi.value_next = value_reg | {2'd0, data_byte[6:0], 7'd0};
                    vi.step_next  = 2'd2;
                end
                else if (data_byte == 8'd0)
                    vi.bad = 1'b1;
                else
                begin
                    vi.ready      = 1'b1;
                    vi.value      = value_reg | {1'b0, data_byte, 7'd0};
                    vi.value_next = vi.value;
                end
            end
            default:
            begin
                if (data_byte[7:2] != 6'd0 || data_byte == 8'd0)
                    vi.bad = 1'b1;
                else
                begin
                    vi.ready      = 1'b1;
                    vi.value      = value_reg | {data_byte[1:0], 14'd0};
                    vi.value_next = vi.value;
                end
            end
        endcase
    end

endmodule

// ===== hdl/ebsp_core.sv =====
// ---------------------------------------------------------------------------
// ebsp_core
// Parser state machine: one byte per cycle while step is high, one result per byte.
// ---------------------------------------------------------------------------
`include "entry_batch_signature_parser_defines.svh"
module ebsp_core #(
    parameter int SIG_CAP          = ebsp_pkg::SigCapDef,
    parameter int MAX_ENTRIES      = ebsp_pkg::MaxEntriesDef,
    parameter int MAX_TX_PER_ENTRY = ebsp_pkg::MaxTxPerEntryDef,
    parameter int MAX_KEYS         = ebsp_pkg::MaxKeysDef,
    parameter int MAX_INSTR        = ebsp_pkg::MaxInstrDef,
    parameter int MAX_LUT          = ebsp_pkg::MaxLutDef
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic [7:0]          data_byte,
    input  logic                last_byte,
    output ebsp_pkg::result_t   res
);

    localparam int CW = $clog2(SIG_CAP + 1);

    ebsp_pkg::phase_t phase_reg, phase_next;
    ebsp_pkg::run_t   run_reg, run_next;
    logic [2:0]  fbi_reg, fbi_next;
    logic [23:0] acc_reg, acc_next;
    logic        ovf_reg, ovf_next;
    logic [16:0] ent_reg, ent_next;
    logic [16:0] txl_reg, txl_next;
    logic [6:0]  nsig_reg, nsig_next;
    logic [15:0] skip_reg, skip_next;
    logic [15:0] vv_reg;
    logic [1:0]  vs_reg;
    logic        ver_reg, ver_next;
    logic [15:0] ixl_reg, ixl_next;
    logic [15:0] lut_reg, lut_next;
    logic [5:0]  spos_reg, spos_next;
    logic [CW-1:0] com_reg, com_next;

    ebsp_pkg::varint_t vi;
    logic        cnt_done;
    logic        cnt_ovf;
    logic [23:0] cnt_val;
    logic        fired;
    logic        vphase;
    logic [15:0] skip_dec;
    logic [15:0] vsum;

    ebsp_varint u_varint
    (
        .data_byte (data_byte),
        .value_reg (vv_reg),
        .step_reg  (vs_reg),
        .vi        (vi)
    );

    // 8-byte count accumulation, only the low three bytes are kept
    always_comb
    begin
        cnt_val = acc_reg;
        cnt_ovf = ovf_reg;
        case (fbi_reg)
            3'd0:    cnt_val = acc_reg | {16'd0, data_byte};
            3'd1:    cnt_val = acc_reg | {8'd0, data_byte, 8'd0};
            3'd2:    cnt_val = acc_reg | {data_byte, 16'd0};
            default: cnt_ovf = ovf_reg | (data_byte != 8'd0);
        endcase
        cnt_done = (fbi_reg == 3'd7);
    end

    assign vphase = (phase_reg == ebsp_pkg::PH_NSIG) || (phase_reg == ebsp_pkg::PH_NKEYS)
        || (phase_reg == ebsp_pkg::PH_NINSTR) || (phase_reg == ebsp_pkg::PH_IXNACC)
        || (phase_reg == ebsp_pkg::PH_IXDLEN) || (phase_reg == ebsp_pkg::PH_LUTNW)
        || (phase_reg == ebsp_pkg::PH_LUTNR) || (phase_reg == ebsp_pkg::PH_NLUT);
    assign skip_dec = (skip_reg != 16'd0) ? skip_reg - 16'd1 : 16'd0;
    assign vsum     = {vi.value[10:0], 5'd0} + 16'd32;

    // next state
    always_comb
    begin
        logic txc, entc, nxi, nxl;
        txc  = 1'b0;
        entc = 1'b0;
        nxi  = 1'b0;
        nxl  = 1'b0;
        phase_next = phase_reg;
        run_next   = run_reg;
        fbi_next   = fbi_reg;
        acc_next   = acc_reg;
        ovf_next   = ovf_reg;
        ent_next   = ent_reg;
        txl_next   = txl_reg;
        nsig_next  = nsig_reg;
        skip_next  = skip_reg;
        ver_next   = ver_reg;
        ixl_next   = ixl_reg;
        lut_next   = lut_reg;
        spos_next  = spos_reg;
        com_next   = com_reg;
        fired      = 1'b0;
        res        = '0;

        if (run_reg == ebsp_pkg::RUN_ACTIVE)
        begin
            case (phase_reg)
                ebsp_pkg::PH_NENT, ebsp_pkg::PH_NTX:
                begin
                    fbi_next = fbi_reg + 3'd1;
                    acc_next = cnt_val;
                    ovf_next = cnt_ovf;
                    if (cnt_done)
                    begin
                        if (phase_reg == ebsp_pkg::PH_NENT)
                        begin
                            if (cnt_ovf || cnt_val == 24'd0
                                || {8'd0, cnt_val} > MAX_ENTRIES)
                                run_next = ebsp_pkg::RUN_FAIL;
                            else
                            begin
                                ent_next   = cnt_val[16:0];
                                phase_next = ebsp_pkg::PH_ESKIP;
                                skip_next  = {10'd0, ebsp_pkg::EntrySkip};
                            end
                        end
                        else if (cnt_ovf || {8'd0, cnt_val} > MAX_TX_PER_ENTRY)
                            run_next = ebsp_pkg::RUN_FAIL;
                        else if (cnt_val == 24'd0)
                            entc = 1'b1;
                        else
                        begin
                            txl_next   = cnt_val[16:0];
                            phase_next = ebsp_pkg::PH_NSIG;
                        end
                    end
                end
                ebsp_pkg::PH_ESKIP:
                begin
                    skip_next = skip_reg - 16'd1;
                    if (skip_reg == 16'd1)
                    begin
                        phase_next = ebsp_pkg::PH_NTX;
                        fbi_next   = 3'd0;
                        acc_next   = '0;
                        ovf_next   = 1'b0;
                    end
                end
                ebsp_pkg::PH_SIG:
                begin
                    res.sig_valid      = 1'b1;
                    res.sig_byte       = data_byte;
                    res.sig_byte_index = spos_reg;
                    res.sig_number     = 12'(com_reg);
                    spos_next          = spos_reg + 6'd1;
                    if (spos_reg == 6'd63)
                    begin
                        skip_next  = {3'd0, nsig_reg - 7'd1, 6'd0};
                        phase_next = (nsig_reg != 7'd1) ? ebsp_pkg::PH_SIGSKIP
                                                        : ebsp_pkg::PH_HDR0;
                    end
                end
                ebsp_pkg::PH_HDR0:
                begin
                    if (data_byte[7])
                    begin
                        if (data_byte[6:0] != 7'd0)
                            run_next = ebsp_pkg::RUN_FAIL;
                        else
                        begin
                            ver_next   = 1'b1;
                            phase_next = ebsp_pkg::PH_HDRV;
                        end
                    end
                    else if ({1'b0, data_byte[6:0]} != {1'b0, nsig_reg})
                        run_next = ebsp_pkg::RUN_FAIL;
                    else
                    begin
                        ver_next   = 1'b0;
                        phase_next = ebsp_pkg::PH_ROSKIP;
                        skip_next  = 16'd2;
                    end
                end
                ebsp_pkg::PH_HDRV:
                begin
                    if (data_byte != {1'b0, nsig_reg})
                        run_next = ebsp_pkg::RUN_FAIL;
                    else
                    begin
                        phase_next = ebsp_pkg::PH_ROSKIP;
                        skip_next  = 16'd2;
                    end
                end
                ebsp_pkg::PH_IXPROG:
                    phase_next = ebsp_pkg::PH_IXNACC;
                ebsp_pkg::PH_SIGSKIP, ebsp_pkg::PH_ROSKIP, ebsp_pkg::PH_KEYSKIP,
                ebsp_pkg::PH_IXACC, ebsp_pkg::PH_IXDATA, ebsp_pkg::PH_LUTKEY,
                ebsp_pkg::PH_LUTW, ebsp_pkg::PH_LUTR:
                begin
                    skip_next = skip_dec;
                    if (skip_dec == 16'd0)
                    begin
                        case (phase_reg)
                            ebsp_pkg::PH_SIGSKIP: phase_next = ebsp_pkg::PH_HDR0;
                            ebsp_pkg::PH_ROSKIP:  phase_next = ebsp_pkg::PH_NKEYS;
                            ebsp_pkg::PH_KEYSKIP: phase_next = ebsp_pkg::PH_NINSTR;
                            ebsp_pkg::PH_IXACC:   phase_next = ebsp_pkg::PH_IXDLEN;
                            ebsp_pkg::PH_IXDATA:
                            begin
                                ixl_next = ixl_reg - 16'd1;
                                nxi      = 1'b1;
                            end
                            ebsp_pkg::PH_LUTKEY:  phase_next = ebsp_pkg::PH_LUTNW;
                            ebsp_pkg::PH_LUTW:    phase_next = ebsp_pkg::PH_LUTNR;
                            default:
                            begin
                                lut_next = lut_reg - 16'd1;
                                nxl      = 1'b1;
                            end
                        endcase
                    end
                end
                default:
                begin
                    if (!vphase)
                        run_next = ebsp_pkg::RUN_FAIL;
                    else if (vi.bad)
                        run_next = ebsp_pkg::RUN_FAIL;
                    else if (vi.ready)
                    begin
                        case (phase_reg)
                            ebsp_pkg::PH_NSIG:
                            begin
                                if (vi.value == 16'd0 || vi.value > 16'(ebsp_pkg::MaxSigs))
                                    run_next = ebsp_pkg::RUN_FAIL;
                                else
                                begin
                                    nsig_next  = vi.value[6:0];
                                    spos_next  = 6'd0;
                                    phase_next = ebsp_pkg::PH_SIG;
                                end
                            end
                            ebsp_pkg::PH_NKEYS:
                            begin
                                if (vi.value == 16'd0 || {16'd0, vi.value} > MAX_KEYS)
                                    run_next = ebsp_pkg::RUN_FAIL;
                                else
                                begin
                                    phase_next = ebsp_pkg::PH_KEYSKIP;
                                    skip_next  = vsum;
                                end
                            end
                            ebsp_pkg::PH_NINSTR:
                            begin
                                if ({16'd0, vi.value} > MAX_INSTR)
                                    run_next = ebsp_pkg::RUN_FAIL;
                                else
                                begin
                                    ixl_next = vi.value;
                                    nxi      = 1'b1;
                                end
                            end
                            ebsp_pkg::PH_NLUT:
                            begin
                                if ({16'd0, vi.value} > MAX_LUT)
                                    run_next = ebsp_pkg::RUN_FAIL;
                                else
                                begin
                                    lut_next = vi.value;
                                    nxl      = 1'b1;
                                end
                            end
                            ebsp_pkg::PH_IXNACC:
                            begin
                                skip_next  = vi.value;
                                phase_next = (vi.value != 16'd0) ? ebsp_pkg::PH_IXACC
                                                                 : ebsp_pkg::PH_IXDLEN;
                            end
                            ebsp_pkg::PH_LUTNW:
                            begin
                                skip_next  = vi.value;
                                phase_next = (vi.value != 16'd0) ? ebsp_pkg::PH_LUTW
                                                                 : ebsp_pkg::PH_LUTNR;
                            end
                            ebsp_pkg::PH_IXDLEN:
                            begin
                                if (vi.value != 16'd0)
                                begin
                                    skip_next  = vi.value;
                                    phase_next = ebsp_pkg::PH_IXDATA;
                                end
                                else
                                begin
                                    ixl_next = ixl_reg - 16'd1;
                                    nxi      = 1'b1;
                                end
                            end
                            default:
                            begin
                                if (vi.value != 16'd0)
                                begin
                                    skip_next  = vi.value;
                                    phase_next = ebsp_pkg::PH_LUTR;
                                end
                                else
                                begin
                                    lut_next = lut_reg - 16'd1;
                                    nxl      = 1'b1;
                                end
                            end
                        endcase
                    end
                end
            endcase

            // follow-on: next instruction, next lookup table
            if (nxi)
            begin
                if (ixl_next != 16'd0)
                    phase_next = ebsp_pkg::PH_IXPROG;
                else if (ver_reg)
                    phase_next = ebsp_pkg::PH_NLUT;
                else
                    txc = 1'b1;
            end
            if (nxl)
            begin
                if (lut_next != 16'd0)
                begin
                    phase_next = ebsp_pkg::PH_LUTKEY;
                    skip_next  = 16'd32;
                end
                else
                    txc = 1'b1;
            end
            // transaction commit
            if (txc)
            begin
                fired    = 1'b1;
                if ({{(32-CW){1'b0}}, com_reg} < SIG_CAP)
                    com_next = com_reg + 1'b1;
                txl_next = txl_reg - 17'd1;
                if (txl_next != 17'd0)
                    phase_next = ebsp_pkg::PH_NSIG;
                else
                    entc = 1'b1;
            end
            if (entc)
            begin
                ent_next = ent_reg - 17'd1;
                if (ent_next != 17'd0)
                begin
                    phase_next = ebsp_pkg::PH_ESKIP;
                    skip_next  = {10'd0, ebsp_pkg::EntrySkip};
                end
                else
                    run_next = ebsp_pkg::RUN_DONE;
            end
        end

        res.tx_done   = fired;
        res.batch_end = last_byte;
        res.sig_count = 13'(com_next);
        if (last_byte)
        begin
            if (run_next == ebsp_pkg::RUN_DONE)
                res.batch_status = ebsp_pkg::StatFull;
            else if (com_next != '0)
                res.batch_status = ebsp_pkg::StatPartial;
            else
                res.batch_status = ebsp_pkg::StatReject;
        end
    end

    // parser state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= ebsp_pkg::PH_NENT;
            run_reg   <= ebsp_pkg::RUN_ACTIVE;
            fbi_reg   <= '0;
            acc_reg   <= '0;
            ovf_reg   <= 1'b0;
            ent_reg   <= '0;
            txl_reg   <= '0;
            nsig_reg  <= '0;
            skip_reg  <= '0;
            vv_reg    <= '0;
            vs_reg    <= '0;
            ver_reg   <= 1'b0;
            ixl_reg   <= '0;
            lut_reg   <= '0;
            spos_reg  <= '0;
            com_reg   <= '0;
        end
        else if (step)
        begin
            if (last_byte)
            begin
                phase_reg <= ebsp_pkg::PH_NENT;
                run_reg   <= ebsp_pkg::RUN_ACTIVE;
                fbi_reg   <= '0;
                acc_reg   <= '0;
                ovf_reg   <= 1'b0;
                ent_reg   <= '0;
                txl_reg   <= '0;
                nsig_reg  <= '0;
                skip_reg  <= '0;
                vv_reg    <= '0;
                vs_reg    <= '0;
                ver_reg   <= 1'b0;
                ixl_reg   <= '0;
                lut_reg   <= '0;
                spos_reg  <= '0;
                com_reg   <= '0;
            end
            else
            begin
                phase_reg <= phase_next;
                run_reg   <= run_next;
                fbi_reg   <= fbi_next;
                acc_reg   <= acc_next;
                ovf_reg   <= ovf_next;
                ent_reg   <= ent_next;
                txl_reg   <= txl_next;
                nsig_reg  <= nsig_next;
                skip_reg  <= skip_next;
                ver_reg   <= ver_next;
                ixl_reg   <= ixl_next;
                lut_reg   <= lut_next;
                spos_reg  <= spos_next;
                com_reg   <= com_next;
                if (run_reg == ebsp_pkg::RUN_ACTIVE && vphase)
                begin
                    vv_reg <= vi.value_next;
                    vs_reg <= vi.bad ? 2'd0 : vi.step_next;
                end
            end
        end
    end

    `EBSP_ASSERT_IMPL(a_cap, clk, rst_n, ({{(32-CW){1'b0}}, com_reg} <= SIG_CAP))
    `EBSP_ASSERT_IMPL(a_sig_phase, clk, rst_n,
        (res.sig_valid |-> (phase_reg == ebsp_pkg::PH_SIG)))
    `EBSP_ASSERT_IMPL(a_commit_step, clk, rst_n,
        ((step && !last_byte && !res.tx_done) |=> $stable(com_reg)))

endmodule

// ===== hdl/ebsp_out.sv =====
// ---------------------------------------------------------------------------
// ebsp_out
// Two-entry skid buffer for result transactions.
// ---------------------------------------------------------------------------
`include "entry_batch_signature_parser_defines.svh"
module ebsp_out
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  ebsp_pkg::result_t  in_res,
    output logic               out_valid,
    input  logic               out_ready,
    output ebsp_pkg::result_t  out_res
);

    ebsp_pkg::result_t main_reg, skid_reg;
    logic main_v_reg, skid_v_reg;

    assign in_ready  = !skid_v_reg;
    assign out_valid = main_v_reg;
    assign out_res   = main_reg;

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_v_reg <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else
        begin
            if (!main_v_reg || out_ready)
            begin
                main_v_reg <= skid_v_reg || (in_valid && in_ready);
                skid_v_reg <= 1'b0;
            end
            else if (in_valid && in_ready)
                skid_v_reg <= 1'b1;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (!main_v_reg || out_ready)
            main_reg <= skid_v_reg ? skid_reg : in_res;
        else if (in_valid && in_ready)
            skid_reg <= in_res;
    end

    `EBSP_ASSERT_IMPL(a_skid_main, clk, rst_n, (skid_v_reg |-> main_v_reg))
    `EBSP_ASSERT_IMPL(a_hold, clk, rst_n,
        ((out_valid && !out_ready) |=> (out_valid && $stable(out_res))))
    `EBSP_ASSERT_IMPL(a_skid_drain, clk, rst_n,
        ((skid_v_reg && out_ready) |=> !skid_v_reg))

endmodule

// ===== hdl/entry_batch_signature_parser.sv =====
// ---------------------------------------------------------------------------
// entry_batch_signature_parser
// Streams the first signature of each transaction in an entry batch.
// ---------------------------------------------------------------------------
// Input channel: one batch byte per handshake (data_byte, last_byte) under
// in_valid/in_ready. Output channel: one result per input byte under
// out_valid/out_ready, carrying signature bytes, tx_done commits, and the
// batch status on the result of the byte marked last_byte.
// Each result is registered in the output stage before it is presented.
// Throughput: one byte per cycle while in_ready is high; the parser state
// machine updates its counters and phase once per accepted byte.
// Reset returns the parser to the entry count field with no committed
// signatures; the same happens after each last_byte.
// When the receiver stalls, a two-entry skid buffer absorbs the result in
// flight and in_ready drops until it drains; nothing is lost or repeated.
// ---------------------------------------------------------------------------
module entry_batch_signature_parser #(
    parameter int SIG_CAP          = ebsp_pkg::SigCapDef,
    parameter int MAX_ENTRIES      = ebsp_pkg::MaxEntriesDef,
    parameter int MAX_TX_PER_ENTRY = ebsp_pkg::MaxTxPerEntryDef,
    parameter int MAX_KEYS         = ebsp_pkg::MaxKeysDef,
    parameter int MAX_INSTR        = ebsp_pkg::MaxInstrDef,
    parameter int MAX_LUT          = ebsp_pkg::MaxLutDef
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        sig_valid,
    output logic [7:0]  sig_byte,
    output logic [11:0] sig_number,
    output logic [5:0]  sig_byte_index,
    output logic        tx_done,
    output logic        batch_end,
    output logic [1:0]  batch_status,
    output logic [12:0] sig_count
);

    ebsp_pkg::result_t core_res, out_res;
    logic step;

    assign step = in_valid && in_ready;

    ebsp_core #(
        .SIG_CAP          (SIG_CAP),
        .MAX_ENTRIES      (MAX_ENTRIES),
        .MAX_TX_PER_ENTRY (MAX_TX_PER_ENTRY),
        .MAX_KEYS         (MAX_KEYS),
        .MAX_INSTR        (MAX_INSTR),
        .MAX_LUT          (MAX_LUT)
    ) u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .res       (core_res)
    );

    ebsp_out u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_res    (core_res),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_res   (out_res)
    );

    assign sig_valid      = out_res.sig_valid;
    assign sig_byte       = out_res.sig_byte;
    assign sig_number     = out_res.sig_number;
    assign sig_byte_index = out_res.sig_byte_index;
    assign tx_done        = out_res.tx_done;
    assign batch_end      = out_res.batch_end;
    assign batch_status   = out_res.batch_status;
    assign sig_count      = out_res.sig_count;

endmodule
